FILE: design/u8u16_pkg.sv
package u8u16_pkg;

   // result kinds
   localparam logic [1:0] KIND_UNIT  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // string terminator
   localparam logic [7:0] END_BYTE = 8'h00;

   // surrogate pair construction
   localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
   localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
   localparam logic [15:0] SURR_OFFSET    = 16'h0040;
   localparam logic [30:0] BMP_LIMIT      = 31'h0000_FFFF;
   localparam logic [30:0] PAIR_LIMIT     = 31'h000E_FFFF;

   // lead byte boundaries
   localparam logic [7:0] LEAD_MIN   = 8'hC0;
   localparam logic [7:0] LEAD_MAX   = 8'hFD;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD5_MIN  = 8'hF8;
   localparam logic [7:0] LEAD6_MIN  = 8'hFC;
   localparam logic [7:0] ASCII_LIMIT = 8'h80;

   // one result item
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] utf16_unit;
      logic [15:0] unit_count;
      logic        last;
   } result_type;

endpackage

FILE: design/utf8_to_utf16_transcoder_core.sv
// UTF-8 to UTF-16 transcoder. One UTF-8 byte is taken per cycle on the req_ channel
// and its results leave on the rsp_ channel: UTF-16 units, an end-of-string item
// carrying the saturating unit count when a zero byte arrives between characters,
// or an error item, after which bytes are dropped up to the next zero byte unless a zero byte caused it.
// Decoding is a single pass of logic between the decoder state and a four-entry
// result queue, so a byte is accepted every cycle unless req_stall is high; it rises
// only when fewer than two queue entries are free, which happens when surrogate pairs
// (two results from one byte) or rsp_stall outpace the one-result-per-cycle output side.
module utf8_to_utf16_transcoder_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_utf16_unit,
   output logic [15:0] rsp_unit_count,
   output logic        rsp_last
);
   import u8u16_pkg::*;

   localparam int QDEPTH = 4;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);

   result_type        q_mem_ff [QDEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  q_count_ff, q_count_in;

   logic              req_transfer;
   logic              rsp_transfer;
   result_type        res0;
   result_type        res1;
   logic [1:0]        res_n;
   logic [1:0]        push_n;
   logic [PTR_W-1:0]  wr_ptr_next;
   result_type        head;

   assign req_stall    = (q_count_ff > CNT_W'(QDEPTH - 2));
   assign req_transfer = req_valid && !req_stall;
   assign rsp_valid    = (q_count_ff != '0);
   assign rsp_transfer = rsp_valid && !rsp_stall;

   u8u16_engine #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_transfer),
      .data_byte (req_data_byte),
      .res0      (res0),
      .res1      (res1),
      .res_n     (res_n)
   );

   // queue pointer and occupancy update
   assign push_n      = req_transfer ? res_n : 2'd0;
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in   = rd_ptr_ff + PTR_W'(rsp_transfer);
   assign q_count_in  = q_count_ff + CNT_W'(push_n) - CNT_W'(rsp_transfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_mem_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         q_mem_ff[wr_ptr_next] <= res1;
      end
   end

   // head of queue drives the result ports
   assign head           = q_mem_ff[rd_ptr_ff];
   assign rsp_kind       = head.kind;
   assign rsp_utf16_unit = head.utf16_unit;
   assign rsp_unit_count = head.unit_count;
   assign rsp_last       = head.last;

   // occupancy never exceeds the queue
   assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= CNT_W'(QDEPTH))
      else $error("result queue overflow");

   // a byte is only taken with room for two results
   assert property (@(posedge clock) disable iff (reset)
      req_transfer |-> (q_count_ff <= CNT_W'(QDEPTH - 2)))
      else $error("byte accepted without queue room");

   // pointers and occupancy agree
   assert property (@(posedge clock) disable iff (reset)
      (q_count_ff == '0 || q_count_ff == CNT_W'(QDEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step");

endmodule

FILE: design/u8u16_engine.sv
module u8u16_engine #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   output u8u16_pkg::result_type  res0,
   output u8u16_pkg::result_type  res1,
   output logic [1:0]             res_n
);
   import u8u16_pkg::*;

   localparam int SAT_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_COLLECT = 2'd1,
      PH_SKIP    = 2'd2
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [30:0]            accum_ff, accum_in;
   logic [2:0]             left_ff, left_in;
   logic [COUNT_WIDTH-1:0] units_ff, units_in;

   logic [30:0]            shifted;
   logic [2:0]             left_dec;
   logic                   err_hit;
   logic                   err_to_idle;
   logic                   emit_hit;
   logic [1:0]             add_n;
   logic [COUNT_WIDTH:0]   units_sum;
   logic [COUNT_WIDTH-1:0] units_add;
   logic [SAT_WIDTH-1:0]   units_ext;
   logic [15:0]            count_out;
   logic [15:0]            high_unit;
   logic [15:0]            low_unit;

   // continuation byte folded into the partial code point
   assign shifted  = {accum_ff[24:0], data_byte[5:0]};
   assign left_dec = left_ff - 3'd1;

   // surrogate halves from the finished value
   assign high_unit = SURR_HIGH_BASE + {6'd0, shifted[19:10]} - SURR_OFFSET;
   assign low_unit  = SURR_LOW_BASE + {6'd0, shifted[9:0]};

   // saturating unit counter
   assign units_sum = {1'b0, units_ff} + (COUNT_WIDTH+1)'(add_n);
   assign units_add = units_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                             : units_sum[COUNT_WIDTH-1:0];

   // count clipped to the 16-bit field
   assign units_ext = SAT_WIDTH'(units_ff);
   assign count_out = (units_ext > SAT_WIDTH'(17'h0FFFF)) ? 16'hFFFF : units_ext[15:0];

   // byte decode and result formation
   always_comb begin
      phase_in    = phase_ff;
      accum_in    = accum_ff;
      left_in     = left_ff;
      units_in    = units_ff;
      res0        = '0;
      res1        = '0;
      res_n       = 2'd0;
      err_hit     = 1'b0;
      err_to_idle = 1'b0;
      emit_hit    = 1'b0;
      add_n       = 2'd0;

      unique case (phase_ff)
         PH_SKIP: begin
            if (data_byte == 8'd0) begin
               phase_in = PH_IDLE;
               accum_in = '0;
               left_in  = '0;
               units_in = '0;
            end
         end
         PH_COLLECT: begin
            if (data_byte[7:6] != 2'b10) begin
               err_hit     = 1'b1;
               err_to_idle = (data_byte == 8'd0);
            end else if (left_dec == 3'd0) begin
               emit_hit = 1'b1;
            end else begin
               accum_in = shifted;
               left_in  = left_dec;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (data_byte == 8'd0) begin
               res0.kind       = KIND_END;
               res0.unit_count = count_out;
               res0.last       = 1'b1;
               res_n           = 2'd1;
               units_in        = '0;
            end else if (data_byte < ASCII_LIMIT) begin
               res0.kind       = KIND_UNIT;
               res0.utf16_unit = {8'd0, data_byte};
               res0.last       = 1'b1;
               res_n           = 2'd1;
               add_n           = 2'd1;
               units_in        = units_add;
            end else if (data_byte < LEAD_MIN || data_byte > LEAD_MAX) begin
               err_hit = 1'b1;
            end else begin
               phase_in = PH_COLLECT;
               if (data_byte < LEAD3_MIN) begin
                  accum_in = {26'd0, data_byte[4:0]};
                  left_in  = 3'd1;
               end else if (data_byte < LEAD4_MIN) begin
                  accum_in = {27'd0, data_byte[3:0]};
                  left_in  = 3'd2;
               end else if (data_byte < LEAD5_MIN) begin
                  accum_in = {28'd0, data_byte[2:0]};
                  left_in  = 3'd3;
               end else if (data_byte < LEAD6_MIN) begin
                  accum_in = {29'd0, data_byte[1:0]};
                  left_in  = 3'd4;
               end else begin
                  accum_in = {30'd0, data_byte[0]};
                  left_in  = 3'd5;
               end
            end
         end
      endcase

      // finished character
      if (emit_hit) begin
         phase_in = PH_IDLE;
         accum_in = '0;
         left_in  = '0;
         if (shifted <= BMP_LIMIT) begin
            res0.kind       = KIND_UNIT;
            res0.utf16_unit = shifted[15:0];
            res0.last       = 1'b1;
            res_n           = 2'd1;
            add_n           = 2'd1;
            units_in        = units_add;
         end else if (shifted <= PAIR_LIMIT) begin
            res0.kind       = KIND_UNIT;
            res0.utf16_unit = high_unit;
            res1.kind       = KIND_UNIT;
            res1.utf16_unit = low_unit;
            res1.last       = 1'b1;
            res_n           = 2'd2;
            add_n           = 2'd2;
            units_in        = units_add;
         end else begin
            err_hit = 1'b1;
         end
      end

      // error result, then drop bytes unless the zero byte caused it
      if (err_hit) begin
         res0        = '0;
         res0.kind   = KIND_ERROR;
         res0.last   = 1'b1;
         res_n       = 2'd1;
         phase_in    = err_to_idle ? PH_IDLE : PH_SKIP;
         accum_in    = '0;
         left_in     = '0;
         units_in    = '0;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         accum_ff <= '0;
         left_ff  <= '0;
         units_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         left_ff  <= left_in;
         units_ff <= units_in;
      end
   end

   // a pair is two units, the low half closing the transfer group
   assert property (@(posedge clock) disable iff (reset)
      (res_n == 2'd2) |-> (!res0.last && res1.last && res0.kind == KIND_UNIT))
      else $error("surrogate pair formed incorrectly");

   // an error always clears the unit count
   assert property (@(posedge clock) disable iff (reset)
      (accept && res_n != 2'd0 && res0.kind == KIND_ERROR) |=> (units_ff == '0))
      else $error("unit count survived an error");

   // collecting always expects at least one more byte
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COLLECT) |-> (left_ff != 3'd0))
      else $error("collecting with no bytes left");

endmodule
